/* src/sha512_pkg.sv */
package sha512_pkg;

  localparam int unsigned Rounds = 80;

  typedef logic [63:0] word_t;

  typedef struct packed {
    logic  first;
    word_t w;
  } rnd_ctl_t;

  localparam word_t IV [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
    64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  localparam word_t K [80] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F,
    64'hE9B5DBA58189DBBC, 64'h3956C25BF348B538, 64'h59F111F1B605D019,
    64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118, 64'hD807AA98A3030242,
    64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235,
    64'hC19BF174CF692694, 64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3,
    64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65, 64'h2DE92C6F592B0275,
    64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F,
    64'hBF597FC7BEEF0EE4, 64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725,
    64'h06CA6351E003826F, 64'h142929670A0E6E70, 64'h27B70A8546D22FFC,
    64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6,
    64'h92722C851482353B, 64'hA2BFE8A14CF10364, 64'hA81A664BBC423001,
    64'hC24B8B70D0F89791, 64'hC76C51A30654BE30, 64'hD192E819D6EF5218,
    64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99,
    64'h34B0BCB5E19B48A8, 64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB,
    64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3, 64'h748F82EE5DEFB2FC,
    64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915,
    64'hC67178F2E372532B, 64'hCA273ECEEA26619C, 64'hD186B8C721C0C207,
    64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178, 64'h06F067AA72176FBA,
    64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC,
    64'h431D67C49C100D4C, 64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A,
    64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
  };

  function automatic word_t ror(word_t v, int unsigned n);
    ror = (v >> n) | (v << (64 - n));
  endfunction

endpackage

/* src/sha512_sched.sv */
// 16-word message schedule window, one word per round
module sha512_sched (
  input  logic                 clk,
  input  logic                 load,
  input  logic [3:0]           load_idx,
  input  sha512_pkg::word_t    load_word,
  input  logic                 step,
  input  logic                 expand,
  output sha512_pkg::word_t    wt
);
  sha512_pkg::word_t win_r [16];
  sha512_pkg::word_t s15, s2, nw;

  always_comb begin
    s15 = win_r[1];
    s2  = win_r[14];
    nw = win_r[0] + win_r[9]
       + (sha512_pkg::ror(s15, 1) ^ sha512_pkg::ror(s15, 8) ^ (s15 >> 7))
       + (sha512_pkg::ror(s2, 19) ^ sha512_pkg::ror(s2, 61) ^ (s2 >> 6));
  end

  // window slides: win_r[0] is always the current round word
  assign wt = win_r[0];

  always_ff @(posedge clk) begin
    if (load) begin
      win_r[load_idx] <= load_word;
    end else if (step) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
      win_r[15] <= expand ? nw : win_r[0];
    end
  end
endmodule

/* src/sha512_round.sv */
// shared round unit with working variables and chaining value
module sha512_compress (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha512_pkg::rnd_ctl_t ctl,
  input  logic                 step,
  input  logic [6:0]           rnd,
  input  logic                 fold,
  input  logic                 reinit,
  input  logic [2:0]           rd_idx,
  output sha512_pkg::word_t    rd_word
);
  sha512_pkg::word_t h_r [8];
  sha512_pkg::word_t v_r [8];
  sha512_pkg::word_t v [8];
  sha512_pkg::word_t t1, t2;

  always_comb begin
    for (int i = 0; i < 8; i++) v[i] = ctl.first ? h_r[i] : v_r[i];
    t1 = v[7] + sha512_pkg::K[rnd] + ctl.w
       + (sha512_pkg::ror(v[4], 14) ^ sha512_pkg::ror(v[4], 18) ^ sha512_pkg::ror(v[4], 41))
       + ((v[4] & v[5]) ^ (~v[4] & v[6]));
    t2 = (sha512_pkg::ror(v[0], 28) ^ sha512_pkg::ror(v[0], 34) ^ sha512_pkg::ror(v[0], 39))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign rd_word = h_r[rd_idx];

  always_ff @(posedge clk) begin
    if (step) begin
      v_r[7] <= v[6];
      v_r[6] <= v[5];
      v_r[5] <= v[4];
      v_r[4] <= v[3] + t1;
      v_r[3] <= v[2];
      v_r[2] <= v[1];
      v_r[1] <= v[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || reinit) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sha512_pkg::IV[i];
    end else if (fold) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end
endmodule

/* src/sha512_hash_engine.sv */
// sha-512 engine
// input channel: in_data_word, in_byte_count, in_last_word under in_valid/in_ready;
//   one beat is one 64-bit big-endian message word. every beat before the last
//   carries 8 bytes; the last beat carries 0..8 leading bytes (9..15 count as 8)
// output channel: out_digest_word, out_word_index, out_digest_last under
//   out_valid/out_ready; eight beats per message, most significant word first
// timing: a word that does not fill a block leaves the engine idle and ready
//   for the next word. the 16th word of a block starts the compression: 80
//   rounds on the shared round unit, one per cycle, then a fold into the
//   chaining value; no new word is taken until the fold is done. the last
//   beat writes padding words one per cycle, runs one or two compressions,
//   then presents the digest beats one per cycle while out_ready is high
// in_ready is low while padding, compressing or presenting the digest
// a stalled receiver holds the current digest beat; nothing is dropped
// reset loads the initial hash value and clears length and word position;
// after the eighth digest beat the engine reloads the initial value
module sha512_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_digest_last
);
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] len_r, len_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        final_r, final_nxt;   // padding has been started
  logic        lenw_r, lenw_nxt;     // length word already written
  logic        need_r, need_nxt;     // 0x80 word after a full last word
  logic        pad14_r, pad14_nxt;   // word 14 was zero fill, room for the length

  logic              ld;
  logic [63:0]       ld_word;
  logic              rstep, fold, reinit;
  sha512_pkg::word_t wt, hword;
  sha512_pkg::rnd_ctl_t ctl;

  logic [3:0]  cnt;
  logic [63:0] keep, marked;
  logic        acc;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign cnt      = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;

  always_comb begin
    keep = (cnt == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> {cnt, 3'b000});
    marked = (in_data_word & keep) | (64'h80 << (7'd56 - {cnt, 3'b000}));
  end

  // new schedule words are only needed for rounds 16..79
  sha512_sched u_sched (
    .clk(clk), .load(ld), .load_idx(pos_r), .load_word(ld_word),
    .step(rstep), .expand(rnd_r < 7'd64), .wt(wt)
  );

  assign ctl.first = (rnd_r == 7'd0);
  assign ctl.w     = wt;

  sha512_compress u_round (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .step(rstep), .rnd(rnd_r),
    .fold(fold), .reinit(reinit), .rd_idx(oidx_r), .rd_word(hword)
  );

  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    len_nxt = len_r;
    rnd_nxt = rnd_r;
    oidx_nxt = oidx_r;
    final_nxt = final_r;
    lenw_nxt = lenw_r;
    need_nxt = need_r;
    pad14_nxt = 1'b0;
    ld = 1'b0;
    ld_word = 64'd0;
    rstep = 1'b0;
    fold = 1'b0;
    reinit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          ld = 1'b1;
          pos_nxt = pos_r + 4'd1;
          if (!in_last_word) begin
            ld_word = in_data_word;
            len_nxt = len_r + 64'd64;
            if (pos_r == 4'd15) state_nxt = ST_ROUND;
          end else begin
            len_nxt = len_r + {57'd0, cnt, 3'b000};
            final_nxt = 1'b1;
            lenw_nxt = 1'b0;
            if (cnt == 4'd8) begin
              ld_word = in_data_word;
              need_nxt = 1'b1;
            end else begin
              ld_word = marked;
              need_nxt = 1'b0;
            end
            state_nxt = (pos_r == 4'd15) ? ST_ROUND : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ld = 1'b1;
        pos_nxt = pos_r + 4'd1;
        if (need_r) begin
          ld_word = 64'h8000_0000_0000_0000;
          need_nxt = 1'b0;
        end else if (pos_r == 4'd15 && pad14_r) begin
          ld_word = len_r;
          lenw_nxt = 1'b1;
        end else begin
          ld_word = 64'd0;
          pad14_nxt = (pos_r == 4'd14);
        end
        if (pos_r == 4'd15) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        rstep = 1'b1;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'(sha512_pkg::Rounds - 1)) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        fold = 1'b1;
        rnd_nxt = 7'd0;
        if (!final_r) state_nxt = ST_IDLE;
        else if (lenw_r) begin
          state_nxt = ST_OUT;
          oidx_nxt = 3'd0;
        end else state_nxt = ST_PAD;
      end
      ST_OUT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            reinit = 1'b1;
            state_nxt = ST_IDLE;
            final_nxt = 1'b0;
            len_nxt = 64'd0;
            pos_nxt = 4'd0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = hword;
  assign out_word_index  = oidx_r;
  assign out_digest_last = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r <= 4'd0;
      len_r <= 64'd0;
      rnd_r <= 7'd0;
      oidx_r <= 3'd0;
      final_r <= 1'b0;
      lenw_r <= 1'b0;
      need_r <= 1'b0;
      pad14_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      rnd_r <= rnd_nxt;
      oidx_r <= oidx_nxt;
      final_r <= final_nxt;
      lenw_r <= lenw_nxt;
      need_r <= need_nxt;
      pad14_r <= pad14_nxt;
    end
  end
endmodule
